[hdl/iba_pkg.sv]
// Package for the indexed block allocator: payload structs, status codes.
// No dependencies.
`timescale 1ns / 1ps
package iba_pkg;
    localparam logic FUNC_CREATE = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EXISTS   = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic        func;
        logic [63:0] file_name;
        logic [19:0] size_bytes;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] file_slot;
        logic [5:0] index_blk;
        logic [5:0] data_block_count;
        logic [6:0] free_count;
    } t_rsp;
endpackage

[hdl/indexed_block_allocator_unit.sv]
// Top level of the indexed block allocator: sequencer, file table, free ring
// and pointer store. Depends on iba_pkg.
//
//  channel | direction | handshake          | payload
//  req     | in        | i_req_valid/o_req_stall | iba_pkg::t_req
//  rsp     | out       | o_rsp_valid/i_rsp_stall | iba_pkg::t_rsp
//
// One item at a time. The name search visits one slot per cycle, then a create
// scans for the lowest free slot the same way. Each data block pop or push waits
// on a registered ring or pointer store read. Reset is synchronous; the ring is
// refilled by a clearing pass after reset, during which no item is accepted. A
// stalled result is held in the output register and the block waits for it.
`timescale 1ns / 1ps
module indexed_block_allocator_unit #(
    parameter int NUM_BLOCKS      = 64,
    parameter int BYTES_PER_BLOCK = 1024,
    parameter int NUM_FILES       = 16,
    parameter int MAX_DATA_BLOCKS = 63
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  iba_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output iba_pkg::t_rsp  o_rsp
);
    import iba_pkg::*;

    localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int SW = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
    localparam int FW = $clog2(NUM_FILES + 1);
    localparam int DW = $clog2(MAX_DATA_BLOCKS + 1);
    localparam int PD = NUM_FILES * MAX_DATA_BLOCKS;
    localparam int PW = (PD > 1) ? $clog2(PD) : 1;
    localparam int SHW = $clog2(BYTES_PER_BLOCK);
    localparam int NW = 21;

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_FIND  = 10'b0000000100,
        S_DEC   = 10'b0000001000,
        S_FREE  = 10'b0000010000,
        S_POPI  = 10'b0000100000,
        S_POPD  = 10'b0001000000,
        S_PUSHD = 10'b0010000000,
        S_PUSHI = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [BW-1:0] ring_mem [NUM_BLOCKS];
    logic [BW-1:0] ptr_mem [PD];
    logic [BW-1:0] r_ring_q, r_ptr_q;

    logic [NUM_FILES-1:0] r_used;
    logic [63:0] slot_name [NUM_FILES];
    logic [DW-1:0] slot_cnt [NUM_FILES];
    logic [BW-1:0] slot_idx [NUM_FILES];

    logic [BW-1:0] r_head, r_tail;
    logic [CW-1:0] r_free;
    logic [FW-1:0] r_files;
    t_req          r_req;
    logic [SW:0]   r_scan;
    logic          r_hit;
    logic [SW-1:0] r_slot;
    logic [DW-1:0] r_cnt, r_i;
    logic [PW-1:0] r_base;
    logic [BW-1:0] r_idx;
    logic [2:0]    r_status;
    logic [BW:0]   r_init;
    logic          r_rv;
    t_rsp          r_rsp;
    logic          r_rd;

    logic [NW-1:0] need;
    logic          create_go, delete_go;
    assign need = (NW'(r_req.size_bytes) + NW'(BYTES_PER_BLOCK - 1)) >> SHW;
    assign create_go = (r_req.func == FUNC_CREATE) && (r_files < FW'(NUM_FILES)) &&
                       !r_hit && (need <= NW'(MAX_DATA_BLOCKS)) &&
                       (need + 1'b1 <= NW'(r_free));
    assign delete_go = (r_req.func != FUNC_CREATE) && r_hit;

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rv;
    assign o_rsp = r_rsp;

    wire [SW-1:0] scan_ix = r_scan[SW-1:0];
    wire [BW-1:0] ring_next_h = (r_head == BW'(NUM_BLOCKS - 1)) ? '0 : r_head + 1'b1;
    wire [BW-1:0] ring_next_t = (r_tail == BW'(NUM_BLOCKS - 1)) ? '0 : r_tail + 1'b1;
    wire [PW-1:0] ptr_addr = r_base + PW'(r_i);

    // Memory ports: ring written on init and push, read at head; pointer
    // store written on data pops, read during data pushes.
    always_ff @(posedge i_clk) begin
        r_ring_q <= ring_mem[r_head];
        r_ptr_q  <= ptr_mem[ptr_addr];
        if (r_state == S_INIT) begin
            ring_mem[r_init[BW-1:0]] <= r_init[BW-1:0];
        end else if (r_state == S_PUSHD && r_rd) begin
            ring_mem[r_tail] <= r_ptr_q;
        end else if (r_state == S_PUSHI) begin
            ring_mem[r_tail] <= r_idx;
        end
        if (r_state == S_POPD && r_rd) begin
            ptr_mem[r_base + PW'(r_i)] <= r_ring_q;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:  if (r_init == (BW+1)'(NUM_BLOCKS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_req_valid) n_state = S_FIND;
            S_FIND:  if (r_hit || r_scan == (SW+1)'(NUM_FILES - 1)) n_state = S_DEC;
            S_DEC:   if (create_go) n_state = S_FREE;
                     else if (delete_go) n_state = S_PUSHD;
                     else n_state = S_OUT;
            S_FREE:  if (!r_used[scan_ix]) n_state = S_POPI;
            S_POPI:  n_state = S_POPD;
            S_POPD:  if (r_rd && r_i == r_cnt - 1'b1) n_state = S_OUT;
                     else if (r_cnt == '0 && r_rd) n_state = S_OUT;
            S_PUSHD: if (r_i == r_cnt) n_state = S_PUSHI;
            S_PUSHI: n_state = S_OUT;
            S_OUT:   if (!r_rv || !i_rsp_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_free  <= CW'(NUM_BLOCKS);
            r_files <= '0;
            r_used  <= '0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_rv && !i_rsp_stall && r_state != S_OUT) r_rv <= 1'b0;
            unique case (r_state)
                S_INIT: r_init <= r_init + 1'b1;
                S_IDLE: if (i_req_valid) begin
                    r_req  <= i_req;
                    r_scan <= '0;
                    r_hit  <= 1'b0;
                end
                S_FIND: begin
                    // The hit flag is registered, so the scan holds on the matching
                    // slot until the flag is set.
                    if (r_used[scan_ix] && slot_name[scan_ix] == r_req.file_name) begin
                        r_hit  <= 1'b1;
                        r_slot <= scan_ix;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_DEC: begin
                    r_status <= ST_OK;
                    r_i <= '0;
                    r_rd <= 1'b0;
                    if (r_req.func == FUNC_CREATE) begin
                        if (r_files >= FW'(NUM_FILES)) r_status <= ST_FULL;
                        else if (r_hit) r_status <= ST_EXISTS;
                        else if (need > NW'(MAX_DATA_BLOCKS) ||
                                 need + 1'b1 > NW'(r_free)) r_status <= ST_NOSPACE;
                        else begin
                            r_scan <= '0;
                            r_cnt <= DW'(need);
                        end
                    end else if (!r_hit) begin
                        r_status <= ST_NOTFOUND;
                    end else begin
                        r_cnt <= slot_cnt[r_slot];
                        r_idx <= slot_idx[r_slot];
                        r_base <= PW'(r_slot) * PW'(MAX_DATA_BLOCKS);
                    end
                end
                S_FREE: begin
                    if (!r_used[scan_ix]) begin
                        r_slot <= scan_ix;
                        r_base <= PW'(scan_ix) * PW'(MAX_DATA_BLOCKS);
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_POPI: begin
                    // Head data was registered in the previous cycle.
                    r_idx <= r_ring_q;
                    r_head <= ring_next_h;
                    r_free <= r_free - 1'b1;
                end
                S_POPD: begin
                    r_rd <= ~r_rd;
                    if (r_rd && r_cnt != '0) begin
                        r_head <= ring_next_h;
                        r_free <= r_free - 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                    if (n_state == S_OUT) begin
                        r_used[r_slot] <= 1'b1;
                        slot_name[r_slot] <= r_req.file_name;
                        slot_cnt[r_slot] <= r_cnt;
                        slot_idx[r_slot] <= r_idx;
                        r_files <= r_files + 1'b1;
                    end
                end
                S_PUSHD: begin
                    r_rd <= ~r_rd;
                    if (r_rd) begin
                        r_tail <= ring_next_t;
                        r_free <= r_free + 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_PUSHI: begin
                    r_tail <= ring_next_t;
                    r_free <= r_free + 1'b1;
                    r_used[r_slot] <= 1'b0;
                    r_files <= r_files - 1'b1;
                end
                S_OUT: if (!r_rv || !i_rsp_stall) begin
                    r_rv <= 1'b1;
                    r_rsp.status <= r_status;
                    r_rsp.free_count <= 7'(r_free);
                    if (r_status == ST_OK) begin
                        r_rsp.file_slot <= 4'(r_slot);
                        r_rsp.index_blk <= 6'(r_idx);
                        r_rsp.data_block_count <= 6'(r_cnt);
                    end else begin
                        r_rsp.file_slot <= '0;
                        r_rsp.index_blk <= '0;
                        r_rsp.data_block_count <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CW'(NUM_BLOCKS)) else $error("free count above block count");
    a_files_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_files <= FW'(NUM_FILES)) else $error("file count above table size");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_req_stall) else $error("ready while busy");
endmodule

[dv/tb_indexed_block_allocator_unit.sv]
// Self-checking testbench for the indexed block allocator: drives create and
// delete items and checks every result against a behavioral file table model.
// Depends on iba_pkg and indexed_block_allocator_unit.
`timescale 1ns / 1ps

class alloc_scoreboard;
    logic [5:0]  ring [64];
    int unsigned head, tail, free_total, files_in_use;
    bit          used [16];
    logic [63:0] names [16];
    int unsigned nblk [16];
    logic [5:0]  iblk [16];
    logic [5:0]  ptrs [16][63];
    iba_pkg::t_rsp pending [$];
    int unsigned errors, creates_ok, deletes_ok, rejects;

    function new();
        for (int i = 0; i < 64; i++) ring[i] = i[5:0];
        head = 0; tail = 0; free_total = 64; files_in_use = 0;
        errors = 0; creates_ok = 0; deletes_ok = 0; rejects = 0;
        for (int i = 0; i < 16; i++) used[i] = 0;
    endfunction

    function int find_slot(logic [63:0] name);
        for (int s = 0; s < 16; s++)
            if (used[s] && names[s] == name) return s;
        return -1;
    endfunction

    function logic [5:0] take_block();
        logic [5:0] b;
        b = ring[head];
        head = (head + 1) % 64;
        if (free_total > 0) free_total--;
        return b;
    endfunction

    function void give_block(logic [5:0] b);
        ring[tail] = b;
        tail = (tail + 1) % 64;
        if (free_total < 64) free_total++;
    endfunction

    // Works out the result of one accepted item and updates the file table.
    function void note_request(iba_pkg::t_req req);
        iba_pkg::t_rsp r;
        int s;
        int unsigned need;
        r = '0;
        r.status = iba_pkg::ST_OK;
        if (req.func == iba_pkg::FUNC_CREATE) begin
            need = (int'(req.size_bytes) + 1023) / 1024;
            s = -1;
            for (int k = 0; k < 16; k++)
                if (!used[k] && s < 0) s = k;
            if (files_in_use >= 16) r.status = iba_pkg::ST_FULL;
            else if (find_slot(req.file_name) >= 0) r.status = iba_pkg::ST_EXISTS;
            else if (need > 63 || need + 1 > free_total) r.status = iba_pkg::ST_NOSPACE;
            else if (s < 0) r.status = iba_pkg::ST_FULL;
            else begin
                iblk[s] = take_block();
                for (int i = 0; i < need; i++) ptrs[s][i] = take_block();
                used[s] = 1; names[s] = req.file_name; nblk[s] = need;
                files_in_use++;
                r.file_slot = s[3:0]; r.index_blk = iblk[s];
                r.data_block_count = need[5:0];
                creates_ok++;
            end
        end else begin
            s = find_slot(req.file_name);
            if (s < 0) r.status = iba_pkg::ST_NOTFOUND;
            else begin
                for (int i = 0; i < nblk[s]; i++) give_block(ptrs[s][i]);
                give_block(iblk[s]);
                used[s] = 0;
                if (files_in_use > 0) files_in_use--;
                r.file_slot = s[3:0]; r.index_blk = iblk[s];
                r.data_block_count = nblk[s][5:0];
                deletes_ok++;
            end
        end
        if (r.status != iba_pkg::ST_OK) rejects++;
        r.free_count = free_total[6:0];
        pending.push_back(r);
    endfunction

    function void check_result(iba_pkg::t_rsp got);
        iba_pkg::t_rsp exp;
        if (pending.size() == 0) begin
            $error("result with no expectation: %h", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.status !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, got.status); errors++;
        end
        if (got.file_slot !== exp.file_slot) begin
            $error("file_slot expected %0d actual %0d", exp.file_slot, got.file_slot);
            errors++;
        end
        if (got.index_blk !== exp.index_blk) begin
            $error("index_blk expected %0d actual %0d", exp.index_blk,
                   got.index_blk);
            errors++;
        end
        if (got.data_block_count !== exp.data_block_count) begin
            $error("data_block_count expected %0d actual %0d", exp.data_block_count,
                   got.data_block_count);
            errors++;
        end
        if (got.free_count !== exp.free_count) begin
            $error("free_count expected %0d actual %0d", exp.free_count, got.free_count);
            errors++;
        end
    endfunction
endclass

module tb_indexed_block_allocator_unit;
    import iba_pkg::*;

    localparam int RANDOM_ITEMS = 1830;
    localparam int CYCLE_LIMIT  = 2000000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_req_valid = 1'b0;
    logic  o_req_stall;
    t_req  i_req = '0;
    logic  o_rsp_valid;
    logic  i_rsp_stall = 1'b0;
    t_rsp  o_rsp;

    alloc_scoreboard sb;
    bit   calm = 0;       // no idling in the final stretch
    bit   hold_off = 0;   // long receiver hold-off request
    int unsigned cycles = 0;
    logic [63:0] pool [8];

    indexed_block_allocator_unit uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Items are noted on the edge where they are accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && i_req_valid && !o_req_stall) sb.note_request(i_req);
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) sb.check_result(o_rsp);
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_rsp_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                i_rsp_stall <= 1'b0;
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 14);
                i_rsp_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_rsp_stall <= 1'b0;
            end
        end
    end

    // Valid stays high from one item to the next unless an idle burst comes.
    task automatic send_item(logic f, logic [63:0] name, logic [19:0] size);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= '{func: f, file_name: name, size_bytes: size};
        do @(posedge i_clk); while (o_req_stall);
    endtask

    // Sizes mostly small so files fit; a few large ones exercise no-space.
    function automatic logic [19:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 20'($urandom_range(0, 20'hFFFFF));
            1: return 20'd0;
            2: return 20'($urandom_range(8 * 1024, 40 * 1024));
            default: return 20'($urandom_range(1, 4096));
        endcase
    endfunction

    initial begin
        sb = new();
        for (int i = 0; i < 8; i++) pool[i] = {$urandom, $urandom};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: empty file, exact block multiples, oversize, duplicates,
        // full table, missing name, extreme names.
        send_item(FUNC_CREATE, 64'h0, 20'd0);
        send_item(FUNC_CREATE, 64'h0, 20'd5);
        send_item(FUNC_CREATE, '1, 20'd1024);
        send_item(FUNC_CREATE, 64'h1, 20'd1025);
        send_item(FUNC_CREATE, 64'h2, 20'hFFFFF);
        send_item(FUNC_CREATE, 64'h3, 20'd64512);
        send_item(FUNC_CREATE, 64'h4, 20'd64513);
        send_item(FUNC_DELETE, 64'h55, 20'd0);
        send_item(FUNC_CREATE, 64'h5, 20'd60000);
        send_item(FUNC_DELETE, 64'h3, 20'hFFFFF);
        send_item(FUNC_DELETE, '1, 20'd0);
        send_item(FUNC_DELETE, 64'h1, 20'd0);
        for (int i = 0; i < 16; i++) send_item(FUNC_CREATE, 64'h100 + i, 20'd0);
        send_item(FUNC_DELETE, 64'h0, 20'd0);
        hold_off = 1;
        for (int i = 0; i < 18; i++) send_item(FUNC_DELETE, 64'h100 + i, 20'd1);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i > RANDOM_ITEMS - 200) calm = 1;
            if ($urandom_range(0, 19) == 0)
                send_item(1'($urandom), {$urandom, $urandom}, 20'($urandom));
            else
                send_item(1'($urandom_range(0, 1)), pool[$urandom_range(0, 7)]
                          ^ 64'($urandom_range(0, 15)), pick_size());
        end
        i_req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d good creates, %0d good deletes, %0d rejected items.",
                 sb.creates_ok, sb.deletes_ok, sb.rejects);
        if (sb.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[sim.f]
hdl/iba_pkg.sv
hdl/indexed_block_allocator_unit.sv
dv/tb_indexed_block_allocator_unit.sv
